[hdl/double_ended_priority_queue_core_assert.svh]
// assertion macros for the double-ended priority queue core
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DEPQ_ASSERT_NOW(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define DEPQ_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);
`else
`define DEPQ_ASSERT_NOW(label, cond, msg)
`define DEPQ_ASSERT_NEXT(label, trig, cond, msg)
`endif
`endif

[hdl/depq_pkg.sv]
package depq_pkg;

	localparam int unsigned CAPACITY_DEF = 1024;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned ENTRY_W = 11;
	localparam int unsigned REQ_W = 2;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DEL_MAX = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DEL_MIN = 2'd2;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP
	} depq_op_t;

	typedef struct packed {
		depq_op_t op;
		logic signed [VALUE_W-1:0] value;
	} depq_cmd_t;

endpackage

[hdl/depq_cell.sv]
module depq_cell #(
	parameter int unsigned CNT_W = 11,
	parameter int unsigned INDEX = 0,
	parameter bit DESCEND = 1'b0
) (
	input  logic                                clk,
	input  depq_pkg::depq_cmd_t                 cmd,
	input  logic [CNT_W-1:0]                    count,
	input  logic signed [depq_pkg::VALUE_W-1:0] prev_data,
	input  logic                                prev_behind,
	input  logic signed [depq_pkg::VALUE_W-1:0] next_data,
	output logic signed [depq_pkg::VALUE_W-1:0] data,
	output logic                                behind
);
	import depq_pkg::*;

	logic signed [VALUE_W-1:0] data_q;
	logic signed [VALUE_W-1:0] data_d;
	logic occupied;
	logic at_tail;
	logic out_of_order;

	assign occupied = count > CNT_W'(INDEX);
	assign at_tail = count == CNT_W'(INDEX);
	assign out_of_order = DESCEND ? (data_q < cmd.value) : (data_q > cmd.value);
	assign behind = occupied && out_of_order;
	assign data = data_q;

	always_comb begin
		data_d = data_q;
		case (cmd.op)
			OP_INSERT: begin
				if (prev_behind) begin
					data_d = prev_data;
				end else if (behind || at_tail) begin
					data_d = cmd.value;
				end
			end
			OP_POP: begin
				data_d = next_data;
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

[hdl/depq_chain.sv]
module depq_chain #(
	parameter int unsigned CAPACITY = depq_pkg::CAPACITY_DEF,
	parameter bit DESCEND = 1'b0,
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                                clk,
	input  depq_pkg::depq_cmd_t                 cmd,
	input  logic [CNT_W-1:0]                    count,
	output logic signed [depq_pkg::VALUE_W-1:0] head_value
);
	import depq_pkg::*;

	logic signed [VALUE_W-1:0] data_w [CAPACITY];
	logic behind_w [CAPACITY];

	assign head_value = data_w[0];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] prev_data;
		logic prev_behind;
		logic signed [VALUE_W-1:0] next_data;

		if (i == 0) begin : g_first
			assign prev_data = data_w[i];
			assign prev_behind = 1'b0;
		end else begin : g_inner
			assign prev_data = data_w[i-1];
			assign prev_behind = behind_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_data = data_w[i];
		end else begin : g_link
			assign next_data = data_w[i+1];
		end

		depq_cell #(
			.CNT_W(CNT_W),
			.INDEX(i),
			.DESCEND(DESCEND)
		) u_cell (
			.clk(clk),
			.cmd(cmd),
			.count(count),
			.prev_data(prev_data),
			.prev_behind(prev_behind),
			.next_data(next_data),
			.data(data_w[i]),
			.behind(behind_w[i])
		);
	end

endmodule

[hdl/double_ended_priority_queue_core.sv]
// latency: the result strobe done is high in the cycle right after the request transfer
// throughput: one request per cycle, busy never rises; two sorted cell rows update in parallel
// the receiver cannot stall: each result is shown for exactly one cycle
// reset clears the entry count and the strobes; cell contents are not cleared
`include "double_ended_priority_queue_core_assert.svh"
module double_ended_priority_queue_core #(
	parameter int unsigned CAPACITY = depq_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [depq_pkg::REQ_W-1:0]          req_type,
	input  logic signed [depq_pkg::VALUE_W-1:0] value,
	output logic                                done,
	output logic                                is_empty,
	output logic signed [depq_pkg::VALUE_W-1:0] max_value,
	output logic signed [depq_pkg::VALUE_W-1:0] min_value,
	output logic [depq_pkg::ENTRY_W-1:0]        entry_count,
	output logic                                insert_dropped
);
	import depq_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic done_q;
	logic dropped_q;
	logic dropped_d;
	logic accept;
	logic full;
	logic empty;
	depq_cmd_t cmd_asc;
	depq_cmd_t cmd_desc;
	logic signed [VALUE_W-1:0] asc_head;
	logic signed [VALUE_W-1:0] desc_head;

	assign busy = 1'b0;
	assign accept = start && !busy;
	assign full = count_q == CNT_W'(CAPACITY);
	assign empty = count_q == '0;

	always_comb begin
		cmd_asc.op = OP_HOLD;
		cmd_asc.value = value;
		cmd_desc.op = OP_HOLD;
		cmd_desc.value = value;
		count_d = count_q;
		dropped_d = 1'b0;
		if (accept) begin
			case (req_type)
				REQ_INSERT: begin
					if (full) begin
						dropped_d = 1'b1;
					end else begin
						cmd_asc.op = OP_INSERT;
						cmd_desc.op = OP_INSERT;
						count_d = count_q + CNT_W'(1);
					end
				end
				REQ_DEL_MAX: begin
					if (!empty) begin
						cmd_desc.op = OP_POP;
						count_d = count_q - CNT_W'(1);
					end
				end
				REQ_DEL_MIN: begin
					if (!empty) begin
						cmd_asc.op = OP_POP;
						count_d = count_q - CNT_W'(1);
					end
				end
				default: begin
					count_d = count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q <= accept;
			dropped_q <= dropped_d;
		end
	end

	// ascending row keeps the minimum at its head
	depq_chain #(
		.CAPACITY(CAPACITY),
		.DESCEND(1'b0)
	) u_asc (
		.clk(clk),
		.cmd(cmd_asc),
		.count(count_q),
		.head_value(asc_head)
	);

	// descending row keeps the maximum at its head
	depq_chain #(
		.CAPACITY(CAPACITY),
		.DESCEND(1'b1)
	) u_desc (
		.clk(clk),
		.cmd(cmd_desc),
		.count(count_q),
		.head_value(desc_head)
	);

	assign done = done_q;
	assign is_empty = empty;
	assign max_value = empty ? '0 : desc_head;
	assign min_value = empty ? '0 : asc_head;
	assign entry_count = ENTRY_W'(count_q);
	assign insert_dropped = dropped_q;

	`DEPQ_ASSERT_NOW(a_count_bound, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`DEPQ_ASSERT_NEXT(a_insert_grows, accept && req_type == REQ_INSERT && !full, count_q == $past(count_q) + CNT_W'(1), "accepted insert did not grow count")
	`DEPQ_ASSERT_NEXT(a_done_follows, accept, done, "transfer without result strobe")
	`DEPQ_ASSERT_NOW(a_drop_with_done, !insert_dropped || done, "drop flag without result strobe")
	`DEPQ_ASSERT_NOW(a_min_le_max, !done || is_empty || min_value <= max_value, "minimum above maximum")

endmodule
